/* sv/fsa_pkg.sv */
`timescale 1ns / 1ps

package fsa_pkg;

	localparam int SLOTS_DEF      = 64;
	localparam int VALUE_BITS_DEF = 16;

	localparam int CMD_W   = 2;
	localparam int STAT_W  = 2;
	localparam int SLOT_W  = 6;
	localparam int CNT_W   = 7;
	localparam int OUT_DW  = 24;
	localparam int OUT_PAD = OUT_DW - SLOT_W - 2 * CNT_W;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR   = 2'd0,
		CMD_LOAD    = 2'd1,
		CMD_REQUEST = 2'd2
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_NOFIT = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic take;
		logic clear;
		logic load;
		logic noop;
		logic scan_start;
		logic scan_run;
		logic claim;
		logic miss;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		cmd_t item_cmd;
		logic hit;
		logic exhausted;
		logic out_free;
	} dp_stat_t;

endpackage

/* sv/first_fit_slot_allocator.sv */
`timescale 1ns / 1ps

// First-fit slot allocator.
// Input stream: tuser carries the command (clear, load, request), tdata the
// value (capacity for a load, size for a request). One result beat per item.
// Output stream: tuser carries the status (placed/done, no fit, table full),
// tdata carries slot, unplaced count and loaded count.
// Capacities live in a single-port-read memory together with a taken bit;
// a request scans it from slot 0 one entry per cycle, so its cost is set by
// that read port: a request that claims slot j reads slots 0 to j, and a
// miss reads every loaded slot (none on an empty table).
// Clear, load and unused commands skip the scan. One item is in flight at a
// time; the next item is accepted the cycle after its result moves to the
// output register, even while that register still waits on the receiver.
// A stalled receiver holds the output beat and, once the next result is
// ready, holds the block as well.
// Reset empties the table and zeroes both counts; no clearing pass is needed,
// since entries at or above the loaded count are never read.

module first_fit_slot_allocator #(
	parameter int SLOTS      = fsa_pkg::SLOTS_DEF,
	parameter int VALUE_BITS = fsa_pkg::VALUE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [((VALUE_BITS+7)/8)*8-1:0]   s_axis_tdata,  // value
	input  logic [fsa_pkg::CMD_W-1:0]         s_axis_tuser,  // cmd
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [fsa_pkg::OUT_DW-1:0]        m_axis_tdata,  // slot, unplaced_count, loaded_count
	output logic [fsa_pkg::STAT_W-1:0]        m_axis_tuser   // status
);

	fsa_pkg::dp_cmd_t  dp_cmd;
	fsa_pkg::dp_stat_t dp_stat;

	logic [fsa_pkg::SLOT_W-1:0] slot;
	logic [fsa_pkg::CNT_W-1:0]  unplaced_count;
	logic [fsa_pkg::CNT_W-1:0]  loaded_count;

	fsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	fsa_dpath #(
		.SLOTS      (SLOTS),
		.VALUE_BITS (VALUE_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (dp_cmd),
		.stat         (dp_stat),
		.in_cmd       (fsa_pkg::cmd_t'(s_axis_tuser)),
		.in_value     (s_axis_tdata[VALUE_BITS-1:0]),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_status   (m_axis_tuser),
		.out_slot     (slot),
		.out_unplaced (unplaced_count),
		.out_loaded   (loaded_count)
	);

	assign m_axis_tdata = {{fsa_pkg::OUT_PAD{1'b0}}, loaded_count, unplaced_count, slot};

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(dp_cmd))
		else $error("controller issued overlapping datapath commands");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input accepted while an item is in flight");

	a_slot_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser != fsa_pkg::STAT_OK)) |-> (slot == '0))
		else $error("failed result carries a nonzero slot");

	a_nofit_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == fsa_pkg::STAT_NOFIT)) |-> (unplaced_count != '0))
		else $error("no-fit result with zero unplaced count");

endmodule

/* sv/fsa_ctrl.sv */
`timescale 1ns / 1ps

module fsa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  fsa_pkg::dp_stat_t stat,
	output fsa_pkg::dp_cmd_t  cmd
);

	fsa_pkg::state_t state_q;
	fsa_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fsa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			fsa_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = fsa_pkg::ST_EXEC;
				end
			end
			fsa_pkg::ST_EXEC: begin
				state_d = fsa_pkg::ST_FINISH;
				case (stat.item_cmd)
					fsa_pkg::CMD_CLEAR: begin
						cmd.clear = 1'b1;
					end
					fsa_pkg::CMD_LOAD: begin
						cmd.load = 1'b1;
					end
					fsa_pkg::CMD_REQUEST: begin
						cmd.scan_start = 1'b1;
						state_d        = fsa_pkg::ST_SCAN;
					end
					default: begin
						cmd.noop = 1'b1;
					end
				endcase
			end
			fsa_pkg::ST_SCAN: begin
				if (stat.hit) begin
					cmd.claim = 1'b1;
					state_d   = fsa_pkg::ST_FINISH;
				end else if (stat.exhausted) begin
					cmd.miss = 1'b1;
					state_d  = fsa_pkg::ST_FINISH;
				end else begin
					cmd.scan_run = 1'b1;
				end
			end
			fsa_pkg::ST_FINISH: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = fsa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fsa_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* sv/fsa_dpath.sv */
`timescale 1ns / 1ps

module fsa_dpath #(
	parameter int SLOTS      = fsa_pkg::SLOTS_DEF,
	parameter int VALUE_BITS = fsa_pkg::VALUE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fsa_pkg::dp_cmd_t            cmd,
	output fsa_pkg::dp_stat_t           stat,
	input  fsa_pkg::cmd_t               in_cmd,
	input  logic [VALUE_BITS-1:0]       in_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [fsa_pkg::STAT_W-1:0]  out_status,
	output logic [fsa_pkg::SLOT_W-1:0]  out_slot,
	output logic [fsa_pkg::CNT_W-1:0]   out_unplaced,
	output logic [fsa_pkg::CNT_W-1:0]   out_loaded
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int TOT_W = $clog2(SLOTS + 1);
	localparam int MEM_W = VALUE_BITS + 1;
	localparam logic [TOT_W-1:0] SLOTS_T = TOT_W'(SLOTS);

	logic [MEM_W-1:0] mem [SLOTS];

	fsa_pkg::cmd_t            item_cmd_q;
	logic [VALUE_BITS-1:0]    value_q;
	logic [TOT_W-1:0]         total_q;
	logic [fsa_pkg::CNT_W-1:0] miss_q;
	logic [TOT_W-1:0]         idx_q;
	logic                     vld_s1;
	logic [MEM_W-1:0]         rd_data_s1;
	logic [IDX_W-1:0]         rd_idx_s1;
	fsa_pkg::status_t         res_status_q;
	logic [fsa_pkg::SLOT_W-1:0] res_slot_q;
	logic                     out_valid_q;
	logic [fsa_pkg::STAT_W-1:0] out_status_q;
	logic [fsa_pkg::SLOT_W-1:0] out_slot_q;
	logic [fsa_pkg::CNT_W-1:0] out_unplaced_q;
	logic [fsa_pkg::CNT_W-1:0] out_loaded_q;

	logic                     full;
	logic                     rd_en;
	logic                     wr_en;
	logic [IDX_W-1:0]         wr_addr;
	logic [MEM_W-1:0]         wr_data;
	logic [IDX_W-1:0]         res_idx;
	logic [IDX_W+fsa_pkg::SLOT_W-1:0] res_idx_ext;
	logic [TOT_W+fsa_pkg::CNT_W-1:0]  tot_ext;
	logic [fsa_pkg::CNT_W-1:0] loaded_sat;

	assign full  = (total_q == SLOTS_T);
	assign rd_en = cmd.scan_run && (idx_q < total_q);

	assign wr_en   = (cmd.load && !full) || cmd.claim;
	assign wr_addr = cmd.claim ? rd_idx_s1 : total_q[IDX_W-1:0];
	assign wr_data = cmd.claim ? {1'b1, rd_data_s1[VALUE_BITS-1:0]} : {1'b0, value_q};

	assign res_idx     = cmd.claim ? rd_idx_s1 : total_q[IDX_W-1:0];
	assign res_idx_ext = {{fsa_pkg::SLOT_W{1'b0}}, res_idx};

	assign tot_ext    = {{fsa_pkg::CNT_W{1'b0}}, total_q};
	assign loaded_sat = (tot_ext > {{TOT_W{1'b0}}, fsa_pkg::CNT_MAX})
		? fsa_pkg::CNT_MAX : tot_ext[fsa_pkg::CNT_W-1:0];

	assign stat.item_cmd  = item_cmd_q;
	assign stat.hit       = vld_s1 && !rd_data_s1[VALUE_BITS]
		&& (rd_data_s1[VALUE_BITS-1:0] >= value_q);
	assign stat.exhausted = !vld_s1 && (idx_q >= total_q);
	assign stat.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[idx_q[IDX_W-1:0]];
			rd_idx_s1  <= idx_q[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			item_cmd_q <= in_cmd;
			value_q    <= in_value;
		end
		if (cmd.clear || cmd.noop) begin
			res_status_q <= fsa_pkg::STAT_OK;
			res_slot_q   <= '0;
		end
		if (cmd.load) begin
			res_status_q <= full ? fsa_pkg::STAT_FULL : fsa_pkg::STAT_OK;
			res_slot_q   <= full ? '0 : res_idx_ext[fsa_pkg::SLOT_W-1:0];
		end
		if (cmd.claim) begin
			res_status_q <= fsa_pkg::STAT_OK;
			res_slot_q   <= res_idx_ext[fsa_pkg::SLOT_W-1:0];
		end
		if (cmd.miss) begin
			res_status_q <= fsa_pkg::STAT_NOFIT;
			res_slot_q   <= '0;
		end
		if (cmd.emit) begin
			out_status_q   <= res_status_q;
			out_slot_q     <= res_slot_q;
			out_unplaced_q <= miss_q;
			out_loaded_q   <= loaded_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			miss_q      <= '0;
			idx_q       <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				total_q <= '0;
				miss_q  <= '0;
			end
			if (cmd.load && !full) begin
				total_q <= total_q + 1'b1;
			end
			if (cmd.miss && (miss_q != fsa_pkg::CNT_MAX)) begin
				miss_q <= miss_q + 1'b1;
			end
			if (cmd.scan_start) begin
				idx_q  <= '0;
				vld_s1 <= 1'b0;
			end
			if (cmd.scan_run) begin
				vld_s1 <= rd_en;
				if (rd_en) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign out_status   = out_status_q;
	assign out_slot     = out_slot_q;
	assign out_unplaced = out_unplaced_q;
	assign out_loaded   = out_loaded_q;

endmodule

/* test/first_fit_slot_allocator_tb.sv */
`timescale 1ns / 1ps

module first_fit_slot_allocator_tb;

	localparam int IN_DW = ((fsa_pkg::VALUE_BITS_DEF + 7) / 8) * 8;
	localparam logic [fsa_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int DRAIN_LIMIT = 400000;
	localparam int TAIL_CYCLES = 100;

	typedef struct {
		logic [fsa_pkg::CMD_W-1:0] op;
		logic [15:0] val;
		bit drain;
	} alloc_cmd_t;

	typedef struct {
		fsa_pkg::status_t status;
		logic [fsa_pkg::SLOT_W-1:0] slot;
		logic [fsa_pkg::CNT_W-1:0] unplaced;
		logic [fsa_pkg::CNT_W-1:0] loaded;
	} alloc_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DW-1:0] s_axis_tdata = '0;  // value
	logic [fsa_pkg::CMD_W-1:0] s_axis_tuser = '0;  // cmd
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [fsa_pkg::OUT_DW-1:0] m_axis_tdata;      // slot, unplaced_count, loaded_count
	logic [fsa_pkg::STAT_W-1:0] m_axis_tuser;      // status

	alloc_cmd_t cmd_q[$];
	alloc_result_t placement_q[$];
	alloc_cmd_t beat;

	logic [15:0] cap_mem[fsa_pkg::SLOTS_DEF];
	logic [fsa_pkg::SLOTS_DEF-1:0] claimed = '0;
	int n_loaded = 0;
	int n_unplaced = 0;

	int n_total = 1;
	int n_sent = 0;
	int n_checked = 0;
	int n_placed = 0;
	int n_missed = 0;
	int n_refused = 0;
	int n_errors = 0;

	first_fit_slot_allocator u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic alloc_result_t place_predict(input logic [fsa_pkg::CMD_W-1:0] op,
			input logic [15:0] val);
		alloc_result_t r;
		bit found;
		r.status = fsa_pkg::STAT_OK;
		r.slot = '0;
		found = 1'b0;
		case (op)
		fsa_pkg::CMD_CLEAR: begin
			claimed = '0;
			n_loaded = 0;
			n_unplaced = 0;
		end
		fsa_pkg::CMD_LOAD: begin
			if (n_loaded >= fsa_pkg::SLOTS_DEF) begin
				r.status = fsa_pkg::STAT_FULL;
			end else begin
				cap_mem[n_loaded] = val;
				claimed[n_loaded] = 1'b0;
				r.slot = fsa_pkg::SLOT_W'(n_loaded);
				n_loaded++;
			end
		end
		fsa_pkg::CMD_REQUEST: begin
			for (int j = 0; j < n_loaded; j++) begin
				if (!found && !claimed[j] && cap_mem[j] >= val) begin
					found = 1'b1;
					claimed[j] = 1'b1;
					r.slot = fsa_pkg::SLOT_W'(j);
				end
			end
			if (!found) begin
				r.status = fsa_pkg::STAT_NOFIT;
				if (n_unplaced < int'(fsa_pkg::CNT_MAX))
					n_unplaced++;
			end
		end
		default: ;
		endcase
		r.unplaced = fsa_pkg::CNT_W'(n_unplaced);
		r.loaded = fsa_pkg::CNT_W'(n_loaded > int'(fsa_pkg::CNT_MAX)
			? int'(fsa_pkg::CNT_MAX) : n_loaded);
		return r;
	endfunction

	function automatic logic [15:0] pick_value();
		case ($urandom_range(0, 9))
		0: return 16'h0000;
		1: return 16'hFFFF;
		2: return 16'($urandom_range(0, 15));
		default: return 16'($urandom);
		endcase
	endfunction

	function automatic int idle_phase();
		return n_sent * 3 / n_total;
	endfunction

	task automatic queue_cmd(input logic [fsa_pkg::CMD_W-1:0] op, input logic [15:0] val,
			input bit drain = 1'b0);
		alloc_cmd_t c;
		c.op = op;
		c.val = val;
		c.drain = drain;
		cmd_q = {cmd_q, c};
	endtask

	task automatic note_fault(input string msg);
		n_errors++;
		if (n_errors <= 10)
			$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				placement_q = {placement_q, place_predict(s_axis_tuser, s_axis_tdata[15:0])};
				n_sent++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (cmd_q.size() != 0 && !(cmd_q[0].drain && placement_q.size() != 0)
				    && $urandom_range(0, 99) >= (idle_phase() == 0 ? 32 :
				                                 idle_phase() == 1 ? 47 : 0)) begin
					beat = cmd_q.pop_front();
					s_axis_tuser <= beat.op;
					s_axis_tdata <= IN_DW'(beat.val);
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t exp_r;
		logic [fsa_pkg::SLOT_W-1:0] got_slot;
		logic [fsa_pkg::CNT_W-1:0] got_unplaced;
		logic [fsa_pkg::CNT_W-1:0] got_loaded;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_slot = m_axis_tdata[fsa_pkg::SLOT_W-1:0];
				got_unplaced = m_axis_tdata[fsa_pkg::SLOT_W +: fsa_pkg::CNT_W];
				got_loaded = m_axis_tdata[fsa_pkg::SLOT_W+fsa_pkg::CNT_W +: fsa_pkg::CNT_W];
				if (placement_q.size() == 0) begin
					note_fault($sformatf("unexpected result beat status=%0d tdata=%h",
						m_axis_tuser, m_axis_tdata));
				end else begin
					exp_r = placement_q.pop_front();
					n_checked++;
					case (exp_r.status)
					fsa_pkg::STAT_FULL: n_refused++;
					fsa_pkg::STAT_NOFIT: n_missed++;
					default: n_placed++;
					endcase
					if (m_axis_tuser !== exp_r.status || got_slot !== exp_r.slot
					    || got_unplaced !== exp_r.unplaced
					    || got_loaded !== exp_r.loaded)
						note_fault($sformatf({"result %0d: expected status=%0d slot=%0d ",
							"unplaced=%0d loaded=%0d, got status=%0d slot=%0d ",
							"unplaced=%0d loaded=%0d"}, n_checked,
							exp_r.status, exp_r.slot, exp_r.unplaced, exp_r.loaded,
							m_axis_tuser, got_slot, got_unplaced, got_loaded));
				end
			end
			m_axis_tready <= $urandom_range(0, 99) >= (idle_phase() == 0 ? 47 :
			                                           idle_phase() == 1 ? 32 : 0);
		end
	end

	initial begin
		int n_rand;
		int episode;
		int n_load;
		int n_req;
		int waited;
		bit first;

		queue_cmd(fsa_pkg::CMD_REQUEST, 16'h0000);
		queue_cmd(CMD_UNUSED, 16'h1234);
		queue_cmd(fsa_pkg::CMD_LOAD, 16'h0000);
		queue_cmd(fsa_pkg::CMD_LOAD, 16'hFFFF);
		queue_cmd(fsa_pkg::CMD_LOAD, 16'h5555);
		queue_cmd(fsa_pkg::CMD_LOAD, 16'hAAAA);
		queue_cmd(fsa_pkg::CMD_REQUEST, 16'h0000);
		queue_cmd(fsa_pkg::CMD_REQUEST, 16'hFFFF);
		queue_cmd(fsa_pkg::CMD_REQUEST, 16'h0001);
		queue_cmd(fsa_pkg::CMD_REQUEST, 16'hAAAB);
		queue_cmd(fsa_pkg::CMD_REQUEST, 16'hAAAA);
		queue_cmd(fsa_pkg::CMD_REQUEST, 16'h0000);
		queue_cmd(fsa_pkg::CMD_LOAD, 16'h8000);
		queue_cmd(fsa_pkg::CMD_REQUEST, 16'h7FFF);
		queue_cmd(CMD_UNUSED, 16'hFFFF);
		queue_cmd(fsa_pkg::CMD_CLEAR, 16'hFFFF, 1'b1);
		queue_cmd(fsa_pkg::CMD_REQUEST, 16'h0000);
		queue_cmd(fsa_pkg::CMD_LOAD, 16'h00FF);
		queue_cmd(fsa_pkg::CMD_CLEAR, 16'h0000);
		queue_cmd(fsa_pkg::CMD_REQUEST, 16'h00FF);

		n_rand = 0;
		episode = 0;
		while (n_rand < 1400) begin
			first = (episode % 20 == 0);
			if (episode == 3) begin
				queue_cmd(fsa_pkg::CMD_CLEAR, pick_value(), first);
				for (int k = 0; k < 135; k++)
					queue_cmd(fsa_pkg::CMD_REQUEST, pick_value());
				n_rand += 136;
				first = 1'b0;
			end
			if ($urandom_range(0, 9) != 0) begin
				queue_cmd(fsa_pkg::CMD_CLEAR, pick_value(), first);
				n_rand++;
				first = 1'b0;
			end
			n_load = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70)
			                                     : $urandom_range(1, 16);
			n_req = $urandom_range(1, n_load + 4);
			while (n_load + n_req > 0) begin
				if ($urandom_range(0, 29) == 0)
					queue_cmd(CMD_UNUSED, pick_value(), first);
				else if ($urandom_range(0, 59) == 0)
					queue_cmd(fsa_pkg::CMD_CLEAR, pick_value(), first);
				else if (n_load > 0 && (n_req == 0 || $urandom_range(0, 2) != 0)) begin
					queue_cmd(fsa_pkg::CMD_LOAD, pick_value(), first);
					n_load--;
				end else begin
					queue_cmd(fsa_pkg::CMD_REQUEST, pick_value(), first);
					n_req--;
				end
				n_rand++;
				first = 1'b0;
			end
			episode++;
		end
		n_total = cmd_q.size();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		waited = 0;
		while ((cmd_q.size() != 0 || s_axis_tvalid || placement_q.size() != 0)
		       && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			if (cmd_q.size() == 0 && !s_axis_tvalid)
				waited++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (placement_q.size() != 0)
			note_fault($sformatf("%0d results never arrived", placement_q.size()));

		$display("Applied %0d commands over %0d sequences; checked %0d results.",
			n_sent, episode, n_checked);
		$display("Outcomes: %0d placed or done, %0d no fit, %0d loads refused, %0d errors.",
			n_placed, n_missed, n_refused, n_errors);
		if (n_errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#20ms;
		$display("Timeout: run did not complete");
		$display("DONE: errors detected");
		$finish;
	end

endmodule
